// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue assertion failed");

// Next-cycle implication, disabled during reset.
`define STQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue assertion failed");

`endif

// File: rtl/stq_pkg.sv
// Package of the sorted timer queue: codes, widths and shared types.
package stq_pkg;

    localparam int unsigned DEF_NUM_SLOTS = 32;
    localparam int unsigned DEF_PIPE_BITS = 8;

    localparam int unsigned SLOT_W = 5;
    localparam int unsigned DL_W   = 32;
    localparam int unsigned TASK_W = 6;
    localparam int unsigned ACT_W  = 3;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned PIPE_W = 8;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned PAD_W  = 3;
    localparam int unsigned PDAT_W = 32;

    localparam logic [TASK_W-1:0] TASK_RESET = 6'd32;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FREE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BIND   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ARM    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CANCEL = 3'd5;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MSG     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    // Slot status codes.
    localparam logic [1:0] SS_FREE  = 2'd0;
    localparam logic [1:0] SS_ALLOC = 2'd1;
    localparam logic [1:0] SS_ARMED = 2'd2;

    // Register index of the task slot, as seen on paddr bit 2.
    localparam logic REG_TASK = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OP,
        S_TICK
    } t_state;

    // One entry of the sorted chain.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [DL_W-1:0]   deadline;
    } t_entry;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [SLOT_W-1:0] rem_slot;
        t_entry            new_entry;
    } t_cell_ctl;

endpackage

// File: rtl/stq_cell.sv
// One cell of the deadline-sorted chain: holds one armed slot and its deadline.
module stq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stq_pkg::t_cell_ctl i_ctl,
    input  stq_pkg::t_entry    i_left,
    input  stq_pkg::t_entry    i_right,
    input  logic               i_left_ge,
    input  logic               i_left_hit,
    output stq_pkg::t_entry    o_entry,
    output logic               o_ge,
    output logic               o_hit
);
    import stq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // The new word belongs at or before this cell when the cell is empty or its deadline is not earlier.
    assign o_ge  = !r_entry.valid || (i_ctl.new_entry.deadline <= r_entry.deadline);
    // This cell or one to its left holds the word being removed.
    assign o_hit = i_left_hit ||
                   (i_ctl.rem && r_entry.valid && (r_entry.slot == i_ctl.rem_slot));
    assign o_entry = r_entry;

    // Shift right on insert, left on removal.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_left_ge) begin
                n_entry = i_left;
            end else if (o_ge) begin
                n_entry = i_ctl.new_entry;
            end
        end else if (o_hit) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.slot     <= n_entry.slot;
        r_entry.deadline <= n_entry.deadline;
    end

endmodule

// File: rtl/sorted_timer_queue_unit.sv
// Top level of the sorted timer queue.
//
// Input words (action, slot, delay, pipe, data) arrive on a valid/ready channel;
// result words leave on another valid/ready channel through an output register.
// Armed slots sit in a chain of cells sorted by deadline, equal deadlines with
// the newest first. For insert, removal and head pop, every cell compares in
// parallel and shifts its word to or from a neighbor.
// A non-tick word gives one reply through the output register; the block takes
// the next word only after that reply has been registered.
// A tick pops each expired slot in turn, with a message for each but the task
// slot, then gives a summary before it takes the next word. Each result is held in
// the output register until taken; a stalled receiver stalls the chain and the FSM.
// Reset empties the chain, frees all slots, clears the count and sets the
// task slot to none. Pipe and data stores are not cleared.
// The APB port holds the task slot at address 0 and may be written when idle.
module sorted_timer_queue_unit #(
    parameter int unsigned NUM_SLOTS = stq_pkg::DEF_NUM_SLOTS,
    parameter int unsigned PIPE_BITS = stq_pkg::DEF_PIPE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [stq_pkg::ACT_W-1:0]         i_action,
    input  logic [stq_pkg::SLOT_W-1:0]        i_slot,
    input  logic [stq_pkg::DL_W-1:0]          i_delay_ticks,
    input  logic [stq_pkg::PIPE_W-1:0]        i_pipe_id,
    input  logic signed [stq_pkg::DATA_W-1:0] i_data_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [stq_pkg::KIND_W-1:0]        o_kind,
    output logic [stq_pkg::SLOT_W-1:0]        o_fired_slot,
    output logic [stq_pkg::PIPE_W-1:0]        o_dest_pipe,
    output logic signed [stq_pkg::DATA_W-1:0] o_msg_data,
    output logic                              o_ok,
    output logic                              o_switch_task,
    output logic                              o_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stq_pkg::PAD_W-1:0]         paddr,
    input  logic [stq_pkg::PDAT_W-1:0]        pwdata,
    output logic [stq_pkg::PDAT_W-1:0]        prdata,
    output logic                              pready
);
    import stq_pkg::*;

    localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Control state.
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   r_sw;
    logic [DL_W-1:0]   r_count;
    logic [1:0]        r_status [NUM_SLOTS];
    logic [TASK_W-1:0] r_task_slot;

    // Latched input word.
    logic [ACT_W-1:0]  r_action;
    logic [SLOT_W-1:0] r_slot;
    logic [DL_W-1:0]   r_delay;
    logic [PIPE_W-1:0] r_pipe_in;
    logic [DATA_W-1:0] r_data_in;

    // Per-slot bound pipe and data.
    logic [PIPE_BITS-1:0] r_pipe [NUM_SLOTS];
    logic [DATA_W-1:0]    r_data [NUM_SLOTS];

    // Output register.
    logic [KIND_W-1:0] r_kind;
    logic [SLOT_W-1:0] r_fired;
    logic [PIPE_W-1:0] r_dest;
    logic [DATA_W-1:0] r_msg;
    logic              r_ok;
    logic              r_swo;
    logic              r_last;

    // Datapath controls from the output decoder.
    logic              in_acc;
    logic              can_emit;
    logic              emit;
    logic [KIND_W-1:0] e_kind;
    logic [SLOT_W-1:0] e_fired;
    logic [PIPE_W-1:0] e_dest;
    logic [DATA_W-1:0] e_msg;
    logic              e_ok;
    logic              e_last;
    logic              st_we;
    logic [SW-1:0]     st_idx;
    logic [1:0]        st_val;
    logic              bind_we;
    logic              sw_set;
    logic              pop;
    t_cell_ctl         ctl;

    logic              slot_ok;
    logic [SW-1:0]     si;
    logic              free_found;
    logic [SW-1:0]     free_idx;
    logic              head_due;
    logic [SW-1:0]     head_idx;
    logic [15:0]       pipe_wide_in;
    logic [15:0]       pipe_wide_out;

    // Chain wires.
    t_entry w_entry [NUM_SLOTS];
    logic   w_ge    [NUM_SLOTS];
    logic   w_hit   [NUM_SLOTS];

    assign in_acc   = i_in_valid && o_in_ready;
    assign can_emit = !r_out_valid || i_out_ready;
    assign slot_ok  = ({1'b0, r_slot} < (SLOT_W + 1)'(NUM_SLOTS));
    assign si       = r_slot[SW-1:0];
    assign head_idx = w_entry[0].slot[SW-1:0];
    assign head_due = w_entry[0].valid && (w_entry[0].deadline <= r_count);
    assign pipe_wide_in  = {8'd0, r_pipe_in};
    assign pipe_wide_out = 16'(r_pipe[head_idx]);

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!free_found && (r_status[i] == SS_FREE)) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    // Sorted chain of cells.
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        t_entry c_left;
        t_entry c_right;
        logic   c_left_ge;
        logic   c_left_hit;
        if (g == 0) begin : g_first
            assign c_left     = ctl.new_entry;
            assign c_left_ge  = 1'b0;
            assign c_left_hit = pop;
        end else begin : g_rest
            assign c_left     = w_entry[g-1];
            assign c_left_ge  = w_ge[g-1];
            assign c_left_hit = w_hit[g-1];
        end
        if (g == NUM_SLOTS - 1) begin : g_end
            assign c_right = '0;
        end else begin : g_mid
            assign c_right = w_entry[g+1];
        end
        stq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_left     (c_left),
            .i_right    (c_right),
            .i_left_ge  (c_left_ge),
            .i_left_hit (c_left_hit),
            .o_entry    (w_entry[g]),
            .o_ge       (w_ge[g]),
            .o_hit      (w_hit[g])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_action == ACT_TICK) ? S_TICK : S_OP;
                end
            end
            S_OP: begin
                if (can_emit) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                if (can_emit && !head_due) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: operation decode, chain commands and result words.
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        emit    = 1'b0;
        e_kind  = KIND_REPLY;
        e_fired = '0;
        e_dest  = '0;
        e_msg   = '0;
        e_ok    = 1'b0;
        e_last  = 1'b0;
        st_we   = 1'b0;
        st_idx  = si;
        st_val  = SS_FREE;
        bind_we = 1'b0;
        sw_set  = 1'b0;
        pop     = 1'b0;
        ctl     = '0;
        ctl.rem_slot           = r_slot;
        ctl.new_entry.valid    = 1'b1;
        ctl.new_entry.slot     = r_slot;
        ctl.new_entry.deadline = r_delay + r_count;
        unique case (r_state)
            S_OP: begin
                if (can_emit) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    unique case (r_action)
                        ACT_ALLOC: begin
                            if (free_found) begin
                                st_we   = 1'b1;
                                st_idx  = free_idx;
                                st_val  = SS_ALLOC;
                                e_ok    = 1'b1;
                                e_fired = SLOT_W'(free_idx);
                            end
                        end
                        ACT_FREE: begin
                            if (slot_ok) begin
                                ctl.rem = (r_status[si] == SS_ARMED);
                                st_we   = 1'b1;
                                st_val  = SS_FREE;
                            end
                        end
                        ACT_BIND: begin
                            bind_we = slot_ok;
                        end
                        ACT_ARM: begin
                            if (slot_ok && (r_status[si] == SS_ALLOC)) begin
                                ctl.ins = 1'b1;
                                st_we   = 1'b1;
                                st_val  = SS_ARMED;
                                e_ok    = 1'b1;
                            end
                        end
                        ACT_CANCEL: begin
                            if (slot_ok && (r_status[si] == SS_ARMED)) begin
                                ctl.rem = 1'b1;
                                st_we   = 1'b1;
                                st_val  = SS_ALLOC;
                                e_ok    = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (can_emit) begin
                    if (head_due) begin
                        pop    = 1'b1;
                        st_we  = 1'b1;
                        st_idx = head_idx;
                        st_val = SS_ALLOC;
                        if (TASK_W'(w_entry[0].slot) == r_task_slot) begin
                            sw_set = 1'b1;
                        end else begin
                            emit    = 1'b1;
                            e_kind  = KIND_MSG;
                            e_fired = w_entry[0].slot;
                            e_dest  = pipe_wide_out[PIPE_W-1:0];
                            e_msg   = r_data[head_idx];
                        end
                    end else begin
                        emit   = 1'b1;
                        e_kind = KIND_SUMMARY;
                        e_last = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sw        <= 1'b0;
            r_count     <= '0;
            r_task_slot <= TASK_RESET;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_status[i] <= SS_FREE;
            end
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_sw <= 1'b0;
                if (i_action == ACT_TICK) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (sw_set) begin
                r_sw <= 1'b1;
            end
            if (st_we) begin
                r_status[st_idx] <= st_val;
            end
            if (psel && penable && pwrite && pready && (paddr[2] == REG_TASK)) begin
                r_task_slot <= pwdata[TASK_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action  <= i_action;
            r_slot    <= i_slot;
            r_delay   <= i_delay_ticks;
            r_pipe_in <= i_pipe_id;
            r_data_in <= i_data_value;
        end
        if (bind_we) begin
            r_pipe[si] <= pipe_wide_in[PIPE_BITS-1:0];
            r_data[si] <= r_data_in;
        end
        if (emit) begin
            r_kind  <= e_kind;
            r_fired <= e_fired;
            r_dest  <= e_dest;
            r_msg   <= e_msg;
            r_ok    <= e_ok;
            r_swo   <= (e_kind == KIND_SUMMARY) && (r_sw || sw_set);
            r_last  <= e_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_fired_slot  = r_fired;
    assign o_dest_pipe   = r_dest;
    assign o_msg_data    = r_msg;
    assign o_ok          = r_ok;
    assign o_switch_task = r_swo;
    assign o_last        = r_last;

    // Register read port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TASK) ? PDAT_W'(r_task_slot) : '0;

endmodule

// File: rtl/stq_checker.sv
// Port-level checker of the timer queue and its bind to the top level.
`include "assert_macros.svh"

module stq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [stq_pkg::KIND_W-1:0] o_kind,
    input logic                       o_ok,
    input logic                       o_switch_task,
    input logic                       o_last
);
    import stq_pkg::*;

    // A stalled result word stays offered.
    `STQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // A tick summary always closes its item.
    `STQ_ASSERT_IMP(a_sum_last, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_SUMMARY), o_last)

    // Expiry messages are never final and never carry ok.
    `STQ_ASSERT_IMP(a_msg_form, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_MSG), !o_last && !o_ok)

    // Only a summary may request a task switch.
    `STQ_ASSERT_IMP(a_sw_sum, i_clk, i_rst_n, o_out_valid && o_switch_task, o_kind == KIND_SUMMARY)

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_kind        (o_kind),
    .o_ok          (o_ok),
    .o_switch_task (o_switch_task),
    .o_last        (o_last)
);

// File: verif/tb.sv
// Testbench of the sorted timer queue: directed and randomized words checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stq_pkg::*;

    localparam int SLOTS = 32;
    localparam logic [6:0] ACT_BAD6 = 7'd6;
    localparam logic [6:0] ACT_BAD7 = 7'd7;

    typedef struct {
        logic [ACT_W-1:0]  action;
        logic [SLOT_W-1:0] slot;
        logic [DL_W-1:0]   delay;
        logic [PIPE_W-1:0] pipe;
        logic [DATA_W-1:0] data;
    } t_word;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [PIPE_W-1:0] pipe;
        logic [DATA_W-1:0] data;
        logic              ok;
        logic              sw;
        logic              last;
    } t_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [ACT_W-1:0]           i_action = '0;
    logic [SLOT_W-1:0]          i_slot = '0;
    logic [DL_W-1:0]            i_delay_ticks = '0;
    logic [PIPE_W-1:0]          i_pipe_id = '0;
    logic signed [DATA_W-1:0]   i_data_value = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [KIND_W-1:0]          o_kind;
    logic [SLOT_W-1:0]          o_fired_slot;
    logic [PIPE_W-1:0]          o_dest_pipe;
    logic signed [DATA_W-1:0]   o_msg_data;
    logic                       o_ok;
    logic                       o_switch_task;
    logic                       o_last;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PAD_W-1:0]           paddr = '0;
    logic [PDAT_W-1:0]          pwdata = '0;
    logic [PDAT_W-1:0]          prdata;
    logic                       pready;

    sorted_timer_queue_unit u_top (.*);

    initial forever #5 i_clk = ~i_clk;

    // Shadow of the timer pool used to predict results.
    logic [31:0]       tick_cnt;
    logic [1:0]        status [SLOTS];
    logic [DL_W-1:0]   deadline [SLOTS];
    logic [PIPE_W-1:0] bound_pipe [SLOTS];
    logic [DATA_W-1:0] bound_data [SLOTS];
    int                armed_chain [$];
    logic [TASK_W-1:0] task_sel;

    t_word   pending_words [$];
    t_result expected_results [$];
    t_word   cur;
    int      errors = 0;
    int      n_results = 0, n_msgs = 0, n_switches = 0, n_ticks = 0;
    bit      calm = 0;
    bit      bound [SLOTS];

    // Compute the results of one accepted word and update the shadow state.
    task automatic apply_word(input t_word w);
        t_result r;
        int h, pos;
        bit sw;
        r = '{KIND_REPLY, '0, '0, '0, 1'b0, 1'b0, 1'b1};
        case (w.action)
            ACT_TICK: begin
                n_ticks++;
                tick_cnt = tick_cnt + 1;
                sw = 0;
                while (armed_chain.size() > 0 && deadline[armed_chain[0]] <= tick_cnt) begin
                    h = armed_chain.pop_front();
                    status[h] = SS_ALLOC;
                    if (h == int'(task_sel)) begin
                        sw = 1;
                    end else begin
                        expected_results.push_back('{KIND_MSG, h[SLOT_W-1:0], bound_pipe[h],
                                                     bound_data[h], 1'b0, 1'b0, 1'b0});
                    end
                end
                r.kind = KIND_SUMMARY;
                r.sw = sw;
            end
            ACT_ALLOC: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (status[i] == SS_FREE) begin
                        status[i] = SS_ALLOC;
                        r.ok = 1'b1;
                        r.slot = i[SLOT_W-1:0];
                        break;
                    end
                end
            end
            ACT_FREE: begin
                if (status[w.slot] == SS_ARMED) begin
                    foreach (armed_chain[i]) if (armed_chain[i] == w.slot) begin
                        armed_chain.delete(i);
                        break;
                    end
                end
                status[w.slot] = SS_FREE;
            end
            ACT_BIND: begin
                bound_pipe[w.slot] = w.pipe;
                bound_data[w.slot] = w.data;
            end
            ACT_ARM: begin
                if (status[w.slot] == SS_ALLOC) begin
                    deadline[w.slot] = w.delay + tick_cnt;
                    status[w.slot] = SS_ARMED;
                    pos = armed_chain.size();
                    foreach (armed_chain[i]) if (deadline[w.slot] <= deadline[armed_chain[i]]) begin
                        pos = i;
                        break;
                    end
                    armed_chain.insert(pos, int'(w.slot));
                    r.ok = 1'b1;
                end
            end
            ACT_CANCEL: begin
                if (status[w.slot] == SS_ARMED) begin
                    foreach (armed_chain[i]) if (armed_chain[i] == w.slot) begin
                        armed_chain.delete(i);
                        break;
                    end
                    status[w.slot] = SS_ALLOC;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        expected_results.push_back(r);
    endtask

    // Word driver: takes pending words and inserts random idle bursts.
    int gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap <= 0;
        end else begin
            if (i_in_valid && o_in_ready) apply_word(cur);
            if (!i_in_valid || o_in_ready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    cur = pending_words.pop_front();
                    i_action <= cur.action;
                    i_slot <= cur.slot;
                    i_delay_ticks <= cur.delay;
                    i_pipe_id <= cur.pipe;
                    i_data_value <= cur.data;
                    i_in_valid <= 1'b1;
                    gap <= (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %h expected %h", n_results, field, got, want);
    endtask

    // Result monitor with random receiver stalls.
    int stall = 0;
    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("MISMATCH unexpected result word, kind %0d", o_kind);
                end else begin
                    e = expected_results.pop_front();
                    if (o_kind == KIND_MSG) n_msgs++;
                    if (o_switch_task) n_switches++;
                    if (o_kind !== e.kind) report("kind", 32'(o_kind), 32'(e.kind));
                    if (o_fired_slot !== e.slot)
                        report("fired_slot", 32'(o_fired_slot), 32'(e.slot));
                    if (o_dest_pipe !== e.pipe)
                        report("dest_pipe", 32'(o_dest_pipe), 32'(e.pipe));
                    if (o_msg_data !== e.data) report("msg_data", o_msg_data, e.data);
                    if (o_ok !== e.ok) report("ok", 32'(o_ok), 32'(e.ok));
                    if (o_switch_task !== e.sw)
                        report("switch_task", 32'(o_switch_task), 32'(e.sw));
                    if (o_last !== e.last) report("last", 32'(o_last), 32'(e.last));
                end
            end
            if (stall > 0) begin
                stall <= stall - 1;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall <= $urandom_range(0, 3);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic push(input logic [ACT_W-1:0] a, input int s, input logic [31:0] d,
                        input logic [31:0] p, input logic [31:0] v);
        pending_words.push_back('{a, s[SLOT_W-1:0], d, p[PIPE_W-1:0], v});
        if (a == ACT_BIND) bound[s] = 1;
    endtask

    // Hold off until the block has delivered everything and gone quiet.
    task automatic drain();
        while (pending_words.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    // Task slot register write over the APB port, setup then access.
    task automatic write_task_slot(input logic [TASK_W-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(v); penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        task_sel = v;
    endtask

    task automatic random_words(input int count);
        int a, s;
        logic [31:0] d;
        repeat (count) begin
            a = $urandom_range(0, 99);
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
            case ($urandom_range(0, 5))
                0: d = $urandom();
                1: d = 32'hffff_ffff - $urandom_range(0, 3);
                default: d = $urandom_range(0, 6);
            endcase
            if (a < 25) push(ACT_TICK, $urandom_range(0, 31), $urandom(), $urandom(), $urandom());
            else if (a < 40) push(ACT_ALLOC, s, $urandom(), $urandom(), $urandom());
            else if (a < 47) push(ACT_FREE, s, $urandom(), $urandom(), $urandom());
            else if (a < 60) push(ACT_BIND, s, d, $urandom(), $urandom());
            else if (a < 85) begin
                if (!bound[s]) push(ACT_BIND, s, 0, $urandom(), $urandom());
                push(ACT_ARM, s, d, $urandom(), $urandom());
            end else if (a < 95) push(ACT_CANCEL, s, 0, 0, 0);
            else push(ACT_W'($urandom_range(6, 7)), s, $urandom(), $urandom(), $urandom());
        end
    endtask

    initial begin
        tick_cnt = 0;
        task_sel = TASK_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            status[i] = SS_FREE;
            deadline[i] = '0;
            bound_pipe[i] = '0;
            bound_data[i] = '0;
            bound[i] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reply fields, rejections, the largest deadline and unknown actions.
        write_task_slot(TASK_RESET);
        push(ACT_ALLOC, 0, 0, 0, 0);
        push(ACT_ALLOC, 0, 0, 0, 0);
        push(ACT_BIND, 0, 0, 32'hff, 32'h7fff_ffff);
        push(ACT_BIND, 1, 32'hffff_ffff, 32'h00, 32'h8000_0000);
        push(ACT_ARM, 0, 0, 0, 0);
        push(ACT_ARM, 0, 5, 0, 0);
        push(ACT_ARM, 2, 5, 0, 0);
        push(ACT_ARM, 1, 32'hffff_ffff, 0, 0);
        push(ACT_CANCEL, 3, 0, 0, 0);
        push(ACT_TICK, 31, 32'hffff_ffff, 32'hff, 32'hffff_ffff);
        push(ACT_CANCEL, 1, 0, 0, 0);
        push(ACT_ARM, 1, 2, 0, 0);
        push(ACT_FREE, 1, 0, 0, 0);
        push(ACT_FREE, 1, 0, 0, 0);
        push(ACT_BIND, 31, 0, 32'h5a, 32'h1234_5678);
        push(ACT_BIND, 31, 0, 32'ha5, 32'hedcb_a987);
        push(ACT_BAD6[ACT_W-1:0], 31, 32'hffff_ffff, 32'hff, 32'hffff_ffff);
        push(ACT_BAD7[ACT_W-1:0], 0, 0, 0, 0);
        push(ACT_TICK, 0, 0, 0, 0);
        push(ACT_TICK, 0, 0, 0, 0);
        drain();

        // Full pool: every slot armed with one deadline, task slot at the top.
        write_task_slot(6'd31);
        for (int i = 0; i < SLOTS; i++) push(ACT_FREE, i, 0, 0, 0);
        for (int i = 0; i <= SLOTS; i++) push(ACT_ALLOC, 0, 0, 0, 0);
        for (int i = 0; i < SLOTS; i++) push(ACT_BIND, i, 0, $urandom(), $urandom());
        for (int i = 0; i < SLOTS; i++) push(ACT_ARM, i, 1, 0, 0);
        push(ACT_TICK, 0, 0, 0, 0);
        drain();

        // Random mix under several task slot settings.
        write_task_slot(6'd0);
        random_words(80);
        drain();
        write_task_slot(6'd63);
        random_words(50);
        drain();
        write_task_slot(6'd3);
        random_words(60);
        calm = 1;
        random_words(30);
        drain();

        $display("Covered %0d ticks, %0d expiry messages and %0d task switches in %0d results.",
                 n_ticks, n_msgs, n_switches, n_results);
        if (errors == 0) begin
            $display("** sorted_timer_queue_unit: PASSED **");
        end else begin
            $display("** sorted_timer_queue_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5ms;
        $display("Run timed out.");
        $display("** sorted_timer_queue_unit: FAILED **");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_timer_queue_unit.sv
rtl/stq_checker.sv
verif/tb.sv
